>>> design/lbnc_pkg.sv
// Package for the lattice boundary node classifier.
// Holds volume sizes, field widths, stencil tables, codes and the
// controller/datapath command and status types. No dependencies.
package lbnc_pkg;

	// Volume dimensions and derived sizes.
	localparam int SIZE_X  = 64;
	localparam int SIZE_Y  = 64;
	localparam int SIZE_Z  = 64;
	localparam int PLANE   = SIZE_X * SIZE_Y;
	localparam int VOXELS  = PLANE * SIZE_Z;
	localparam int ADDR_W  = $clog2(VOXELS);
	localparam int COORD_W = 6;
	localparam int DIM_W   = 9;
	localparam int LABEL_W = 3;

	// D3Q19 stencil: the rest direction plus 18 neighbours.
	localparam int DIRS     = 19;
	localparam int DIR_W    = $clog2(DIRS);
	localparam int DIR_LAST = DIRS - 1;

	// Item modes.
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Per-axis step of one stencil direction.
	typedef enum logic [1:0] {
		ST_0,
		ST_P,
		ST_M
	} step_t;

	localparam step_t STEP_X_TAB [DIRS] = '{
		ST_0, ST_P, ST_M, ST_0, ST_0, ST_0, ST_0, ST_P, ST_M, ST_P,
		ST_M, ST_P, ST_M, ST_P, ST_M, ST_0, ST_0, ST_0, ST_0};
	localparam step_t STEP_Y_TAB [DIRS] = '{
		ST_0, ST_0, ST_0, ST_P, ST_M, ST_0, ST_0, ST_P, ST_P, ST_M,
		ST_M, ST_0, ST_0, ST_0, ST_0, ST_P, ST_M, ST_P, ST_M};
	localparam step_t STEP_Z_TAB [DIRS] = '{
		ST_0, ST_0, ST_0, ST_0, ST_0, ST_P, ST_M, ST_0, ST_0, ST_0,
		ST_0, ST_P, ST_P, ST_M, ST_M, ST_P, ST_P, ST_M, ST_M};

	// Result labels.
	typedef enum logic [LABEL_W-1:0] {
		LBL_FLUID  = 3'd0,
		LBL_SOLID  = 3'd1,
		LBL_NEAR   = 3'd2,
		LBL_INLET  = 3'd3,
		LBL_OUTLET = 3'd4
	} label_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             write;
		logic             load;
		logic             rd_en;
		logic [DIR_W-1:0] dir;
		logic             result_load;
	} lbnc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic range_ok;
		logic out_free;
	} lbnc_stat_t;

	// Step one coordinate by -1, 0 or +1 with periodic wrap.
	function automatic logic [COORD_W-1:0] wrap_step(
		input logic [COORD_W-1:0] c,
		input step_t              d,
		input logic [DIM_W-1:0]   size
	);
		logic [DIM_W-1:0] nxt;
		nxt = DIM_W'(c) + DIM_W'(1);
		unique case (d)
			ST_P: return (nxt >= size) ? '0 : COORD_W'(nxt);
			ST_M: return (c == '0) ? COORD_W'(size - DIM_W'(1)) : c - COORD_W'(1);
			default: return c;
		endcase
	endfunction

	// Linear voxel address, x running fastest.
	function automatic logic [ADDR_W-1:0] voxel_addr(
		input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y,
		input logic [COORD_W-1:0] z
	);
		return ADDR_W'(ADDR_W'(z) * ADDR_W'(PLANE))
			+ ADDR_W'(ADDR_W'(y) * ADDR_W'(SIZE_X))
			+ ADDR_W'(x);
	endfunction

endpackage

>>> design/lbnc_if.sv
// Channel interfaces for the lattice boundary node classifier.
// Depends on lbnc_pkg for field widths.
interface lbnc_in_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [lbnc_pkg::COORD_W-1:0] pos_x;
	logic [lbnc_pkg::COORD_W-1:0] pos_y;
	logic [lbnc_pkg::COORD_W-1:0] pos_z;
	logic                        solid;

	modport source(output valid, mode, pos_x, pos_y, pos_z, solid, input ready);
	modport sink(input valid, mode, pos_x, pos_y, pos_z, solid, output ready);
endinterface

interface lbnc_out_if;
	logic                        valid;
	logic                        ready;
	logic [lbnc_pkg::LABEL_W-1:0] label;

	modport source(output valid, label, input ready);
	modport sink(input valid, label, output ready);
endinterface

>>> design/lattice_boundary_node_classifier_unit.sv
// Lattice boundary node classifier: voxel solid map with D3Q19 boundary
// labeling. Top level joining controller and datapath.
// Depends on lbnc_pkg, lbnc_if, lbnc_ctrl and lbnc_datapath.
//
// Usage:
//   item   - input channel. A word with mode write stores the solid flag of
//            voxel (pos_x, pos_y, pos_z) and gives no result. A word with mode
//            query gives one label word on result.
//            Words with a coordinate outside the volume are dropped.
//   result - output channel carrying the label: 0 fluid, 1 solid, 2 fluid
//            next to solid, 3 inlet plane, 4 outlet plane.
// A query reads the voxel and its 18 neighbours from a single-port bit
// memory, one read per cycle; the read data is registered and folded into
// the flags, then the label is loaded into the output register, and the
// next word is taken in the cycle after that load. Writes are taken one
// per cycle while no query is running. Query only after every voxel was
// written; the memory is not cleared at reset. Reset empties the output
// register and returns the controller to idle. When the receiver stalls,
// the label waits in the output register while further writes and one
// more query proceed, holding in its last step until the register frees.
module lattice_boundary_node_classifier_unit (
	input logic         clk,
	input logic         arst_n,
	lbnc_in_if.sink     item,
	lbnc_out_if.source  result
);

	lbnc_pkg::lbnc_cmd_t  cmd;
	lbnc_pkg::lbnc_stat_t stat;

	lbnc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_mode  (item.mode),
		.in_ready (item.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lbnc_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_x     (item.pos_x),
		.in_y     (item.pos_y),
		.in_z     (item.pos_z),
		.in_solid (item.solid),
		.result   (result)
	);

endmodule

>>> design/lbnc_datapath.sv
// Datapath: voxel bit memory, neighbour address generation, label
// accumulation and the output word register. Depends on lbnc_pkg, lbnc_if.
module lbnc_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lbnc_pkg::lbnc_cmd_t          cmd,
	output lbnc_pkg::lbnc_stat_t         stat,
	input  logic [lbnc_pkg::COORD_W-1:0] in_x,
	input  logic [lbnc_pkg::COORD_W-1:0] in_y,
	input  logic [lbnc_pkg::COORD_W-1:0] in_z,
	input  logic                         in_solid,
	lbnc_out_if.source                   result
);

	logic solid_map [lbnc_pkg::VOXELS];

	logic [lbnc_pkg::COORD_W-1:0] x_q, y_q, z_q;
	logic [lbnc_pkg::COORD_W-1:0] nx, ny, nz;
	logic [lbnc_pkg::ADDR_W-1:0]  mem_addr;
	logic                         rd_data_s1;
	logic                         rd_vld_s1;
	logic                         rd_ctr_s1;
	logic                         center_q;
	logic                         near_q;
	logic                         out_valid_q;
	lbnc_pkg::label_t             label_q;
	lbnc_pkg::label_t             label_d;

	// Coordinates in range for the incoming word.
	assign stat.range_ok = (lbnc_pkg::DIM_W'(in_x) < lbnc_pkg::DIM_W'(lbnc_pkg::SIZE_X))
		&& (lbnc_pkg::DIM_W'(in_y) < lbnc_pkg::DIM_W'(lbnc_pkg::SIZE_Y))
		&& (lbnc_pkg::DIM_W'(in_z) < lbnc_pkg::DIM_W'(lbnc_pkg::SIZE_Z));
	assign stat.out_free = !out_valid_q || result.ready;

	// Neighbour coordinates for the current stencil direction.
	always_comb begin
		nx = lbnc_pkg::wrap_step(x_q, lbnc_pkg::STEP_X_TAB[cmd.dir],
			lbnc_pkg::DIM_W'(lbnc_pkg::SIZE_X));
		ny = lbnc_pkg::wrap_step(y_q, lbnc_pkg::STEP_Y_TAB[cmd.dir],
			lbnc_pkg::DIM_W'(lbnc_pkg::SIZE_Y));
		nz = lbnc_pkg::wrap_step(z_q, lbnc_pkg::STEP_Z_TAB[cmd.dir],
			lbnc_pkg::DIM_W'(lbnc_pkg::SIZE_Z));
	end

	// Single memory port: writes use the incoming word, reads the stencil.
	assign mem_addr = cmd.write ? lbnc_pkg::voxel_addr(in_x, in_y, in_z)
		: lbnc_pkg::voxel_addr(nx, ny, nz);

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			solid_map[mem_addr] <= in_solid;
		end
		rd_data_s1 <= solid_map[mem_addr];
	end

	// Query coordinates and read tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			rd_ctr_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			rd_ctr_s1 <= (cmd.dir == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= in_x;
			y_q <= in_y;
			z_q <= in_z;
		end
	end

	// Fold each read bit into the center or neighbour flag.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			center_q <= 1'b0;
			near_q   <= 1'b0;
		end else if (rd_vld_s1) begin
			if (rd_ctr_s1) begin
				center_q <= rd_data_s1;
			end else begin
				near_q <= near_q | rd_data_s1;
			end
		end
	end

	// Label from the gathered flags and the z plane.
	always_comb begin
		priority if (center_q) begin
			label_d = lbnc_pkg::LBL_SOLID;
		end else if (near_q) begin
			label_d = lbnc_pkg::LBL_NEAR;
		end else if (z_q == '0) begin
			label_d = lbnc_pkg::LBL_INLET;
		end else if (lbnc_pkg::DIM_W'(z_q) == lbnc_pkg::DIM_W'(lbnc_pkg::SIZE_Z - 1)) begin
			label_d = lbnc_pkg::LBL_OUTLET;
		end else begin
			label_d = lbnc_pkg::LBL_FLUID;
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			label_q <= label_d;
		end
	end

	assign result.valid = out_valid_q;
	assign result.label = label_q;

endmodule

>>> design/lbnc_ctrl.sv
// Controller: takes input words, sequences the 19 stencil reads of a query
// and hands the finished label to the output register. Depends on lbnc_pkg.
module lbnc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_mode,
	output logic                 in_ready,
	input  lbnc_pkg::lbnc_stat_t stat,
	output lbnc_pkg::lbnc_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t                     state_q;
	logic [lbnc_pkg::DIR_W-1:0] dir_q;
	logic                       take;

	assign in_ready = (state_q == S_IDLE);
	assign take     = in_valid && in_ready;

	// Commands decoded from the state and the accepted input word.
	always_comb begin
		cmd.write       = take && (in_mode == lbnc_pkg::MODE_WRITE) && stat.range_ok;
		cmd.load        = take && (in_mode == lbnc_pkg::MODE_QUERY) && stat.range_ok;
		cmd.rd_en       = (state_q == S_RUN);
		cmd.dir         = dir_q;
		cmd.result_load = (state_q == S_DONE) && stat.out_free;
	end

	// State and direction counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dir_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					dir_q <= '0;
					if (cmd.load) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (dir_q == lbnc_pkg::DIR_W'(lbnc_pkg::DIR_LAST)) begin
						dir_q   <= '0;
						state_q <= S_DRAIN;
					end else begin
						dir_q <= dir_q + lbnc_pkg::DIR_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A sweep ends after exactly the last stencil direction.
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && dir_q == lbnc_pkg::DIR_W'(lbnc_pkg::DIR_LAST))
		|=> (state_q == S_DRAIN))
		else $error("stencil sweep did not end after the last direction");

	// The direction counter never passes the stencil size.
	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		dir_q <= lbnc_pkg::DIR_W'(lbnc_pkg::DIR_LAST))
		else $error("direction counter out of range");

	// A pending result word is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |-> stat.out_free)
		else $error("result loaded while output register busy");

	// The single memory port is never asked for a write and a read together.
	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> !cmd.rd_en)
		else $error("memory write and read in the same cycle");

	// A query load starts a sweep from the rest direction.
	a_sweep_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_RUN && dir_q == '0))
		else $error("query did not start a sweep at direction zero");

endmodule
